/* rtl/rlr_pkg.sv */
// shared types and constants for the relu relaxation unit
package rlr_pkg;

  localparam int NUM_W = 63;
  localparam int QUO_W = 31;
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W = 2;
  localparam int CNT_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HEUR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TWO = 2'd1;

  typedef enum logic [1:0] {
    KIND_INACT,
    KIND_ACTIVE,
    KIND_CROSS
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        lo_one;
    logic        has_aux;
    logic        aux_one;
    logic [31:0] onl;
    logic [30:0] oup;
  } meta_t;

  typedef struct packed {
    meta_t            meta;
    logic [31:0]      w;
    logic [NUM_W-1:0] num_l;
    logic [NUM_W-1:0] num_o;
  } item_t;

endpackage

/* rtl/rlr_front.sv */
// front end: input register, classification, product and numerators
module rlr_front import rlr_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int INDEX_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [31:0]            neg_lower,
  input  logic [31:0]            upper,
  input  logic [INDEX_WIDTH-1:0] neuron_index,
  input  logic                   last_in,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic                   cfg_data,
  input  logic [CNT_W-1:0]       q_count,
  output logic                   push,
  output item_t                  push_item,
  output logic [INDEX_WIDTH-1:0] push_idx,
  output logic                   push_last
);

  logic                   heur;
  logic                   two;
  logic                   a_valid;
  logic [31:0]            a_nl;
  logic [31:0]            a_up;
  logic [INDEX_WIDTH-1:0] a_idx;
  logic                   a_last;
  logic                   b_valid;
  meta_t                  b_meta;
  logic [30:0]            b_u;
  logic [31:0]            b_w;
  logic [61:0]            b_prod;
  logic [INDEX_WIDTH-1:0] b_idx;
  logic                   b_last;
  logic                   up_pos;
  logic                   nl_neg;
  logic [30:0]            u;
  logic [30:0]            n;
  meta_t                  meta_next;

  assign in_stall = (4'(q_count) + 4'(a_valid) + 4'(b_valid)) >= 4'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      heur <= 1'b1;
      two <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_HEUR) begin
        heur <= cfg_data;
      end else if (cfg_index == REG_TWO) begin
        two <= cfg_data;
      end
    end
  end

  always_comb begin
    up_pos = !a_up[31] && (a_up != 32'd0);
    nl_neg = a_nl[31];
    u = up_pos ? a_up[30:0] : 31'd0;
    n = (up_pos && !nl_neg) ? a_nl[30:0] : 31'd0;
    meta_next.onl = nl_neg ? a_nl : 32'd0;
    meta_next.oup = u;
    meta_next.kind = KIND_INACT;
    meta_next.lo_one = 1'b0;
    meta_next.has_aux = 1'b0;
    meta_next.aux_one = 1'b0;
    if (up_pos && nl_neg) begin
      meta_next.kind = KIND_ACTIVE;
      meta_next.lo_one = 1'b1;
    end else if (up_pos) begin
      meta_next.kind = KIND_CROSS;
      meta_next.lo_one = heur && !(u < n);
      meta_next.has_aux = two;
      meta_next.aux_one = two && !(heur && !(u < n));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= in_valid && !in_stall;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_nl <= neg_lower;
      a_up <= upper;
      a_idx <= neuron_index;
      a_last <= last_in;
    end
    b_meta <= meta_next;
    b_u <= u;
    b_w <= 32'(u) + 32'(n);
    b_prod <= 62'(u) * 62'(n);
    b_idx <= a_idx;
    b_last <= a_last;
  end

  always_comb begin
    push = b_valid;
    push_item.meta = b_meta;
    push_item.w = b_w;
    push_item.num_l = (NUM_W'(b_u) << FRAC_BITS) + NUM_W'(b_w) - NUM_W'(1);
    push_item.num_o = NUM_W'(b_prod) + NUM_W'(b_w) - NUM_W'(1);
    push_idx = b_idx;
    push_last = b_last;
  end

endmodule

/* rtl/rlr_queue.sv */
// short item queue between front and back
module rlr_queue import rlr_pkg::*; #(
  parameter int INDEX_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  item_t                  push_item,
  input  logic [INDEX_WIDTH-1:0] push_idx,
  input  logic                   push_last,
  input  logic                   pop,
  output item_t                  pop_item,
  output logic [INDEX_WIDTH-1:0] pop_idx,
  output logic                   pop_last,
  output logic                   nonempty,
  output logic [CNT_W-1:0]       count
);

  item_t                  mem_item [QUEUE_DEPTH];
  logic [INDEX_WIDTH-1:0] mem_idx [QUEUE_DEPTH];
  logic                   mem_last [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;

  assign nonempty = count != '0;
  assign pop_item = mem_item[rd_ptr];
  assign pop_idx = mem_idx[rd_ptr];
  assign pop_last = mem_last[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_item[wr_ptr] <= push_item;
      mem_idx[wr_ptr] <= push_idx;
      mem_last[wr_ptr] <= push_last;
    end
  end

endmodule

/* rtl/rlr_back.sv */
// back end: pipelined dual divider and result register
module rlr_back import rlr_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int INDEX_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_nonempty,
  input  item_t                  q_item,
  input  logic [INDEX_WIDTH-1:0] q_idx,
  input  logic                   q_last,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            out_neg_lower,
  output logic [30:0]            out_upper,
  output logic [16:0]            lower_slope,
  output logic [16:0]            upper_slope,
  output logic [30:0]            upper_offset,
  output logic                   has_aux,
  output logic [16:0]            aux_lower_slope,
  output logic [INDEX_WIDTH-1:0] index_out,
  output logic                   last_out
);

  localparam logic [16:0] ONE_Q = 17'(64'(1) << FRAC_BITS);

  logic                   en;
  logic                   v    [QUO_W+1];
  logic [31:0]            rl   [QUO_W+1];
  logic [31:0]            ro   [QUO_W+1];
  logic [QUO_W-1:0]       ll   [QUO_W+1];
  logic [QUO_W-1:0]       lo   [QUO_W+1];
  logic [QUO_W-1:0]       ql   [QUO_W+1];
  logic [QUO_W-1:0]       qo   [QUO_W+1];
  logic [31:0]            w    [QUO_W+1];
  meta_t                  m    [QUO_W+1];
  logic [INDEX_WIDTH-1:0] idx  [QUO_W+1];
  logic                   last [QUO_W+1];
  meta_t                  fm;

  assign en = !(out_valid && out_stall);
  assign pop = q_nonempty && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rl[0] <= q_item.num_l[NUM_W-1:QUO_W];
      ro[0] <= q_item.num_o[NUM_W-1:QUO_W];
      ll[0] <= q_item.num_l[QUO_W-1:0];
      lo[0] <= q_item.num_o[QUO_W-1:0];
      ql[0] <= '0;
      qo[0] <= '0;
      w[0] <= q_item.w;
      m[0] <= q_item.meta;
      idx[0] <= q_idx;
      last[0] <= q_last;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    logic [32:0] tl;
    logic [32:0] to;
    logic        gl;
    logic        go;

    always_comb begin
      tl = {rl[k-1], ll[k-1][QUO_W-1]};
      to = {ro[k-1], lo[k-1][QUO_W-1]};
      gl = tl >= {1'b0, w[k-1]};
      go = to >= {1'b0, w[k-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rl[k] <= gl ? 32'(tl - {1'b0, w[k-1]}) : tl[31:0];
        ro[k] <= go ? 32'(to - {1'b0, w[k-1]}) : to[31:0];
        ll[k] <= ll[k-1] << 1;
        lo[k] <= lo[k-1] << 1;
        ql[k] <= {ql[k-1][QUO_W-2:0], gl};
        qo[k] <= {qo[k-1][QUO_W-2:0], go};
        w[k] <= w[k-1];
        m[k] <= m[k-1];
        idx[k] <= idx[k-1];
        last[k] <= last[k-1];
      end
    end
  end

  assign fm = m[QUO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_neg_lower <= fm.onl;
      out_upper <= fm.oup;
      index_out <= idx[QUO_W];
      last_out <= last[QUO_W];
      has_aux <= fm.has_aux;
      aux_lower_slope <= fm.aux_one ? ONE_Q : 17'd0;
      lower_slope <= fm.lo_one ? ONE_Q : 17'd0;
      case (fm.kind)
        KIND_ACTIVE: begin
          upper_slope <= ONE_Q;
          upper_offset <= 31'd0;
        end
        KIND_CROSS: begin
          upper_slope <= ql[QUO_W][16:0];
          upper_offset <= qo[QUO_W][30:0];
        end
        default: begin
          upper_slope <= 17'd0;
          upper_offset <= 31'd0;
        end
      endcase
    end
  end

endmodule

/* rtl/relu_linear_relaxation_top.sv */
// top level of the relu linear relaxation unit
// Takes one neuron interval per cycle while in_stall is low and returns one
// result item per item. Each item passes through the input register, the
// product stage, the queue, a divider load stage, 31 divider steps that compute
// both rounded-up quotients side by side, and the result register. Throughput
// is one item per cycle while neither in_stall nor out_stall holds.
// Configuration writes are always ready and apply to items classified after the
// write, so write only while idle.
module relu_linear_relaxation_top import rlr_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int INDEX_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [31:0]            neg_lower,
  input  logic [31:0]            upper,
  input  logic [INDEX_WIDTH-1:0] neuron_index,
  input  logic                   last_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            out_neg_lower,
  output logic [30:0]            out_upper,
  output logic [16:0]            lower_slope,
  output logic [16:0]            upper_slope,
  output logic [30:0]            upper_offset,
  output logic                   has_aux,
  output logic [16:0]            aux_lower_slope,
  output logic [INDEX_WIDTH-1:0] index_out,
  output logic                   last_out,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic                   cfg_data
);

  logic                   push;
  item_t                  push_item;
  logic [INDEX_WIDTH-1:0] push_idx;
  logic                   push_last;
  logic                   pop;
  item_t                  q_item;
  logic [INDEX_WIDTH-1:0] q_idx;
  logic                   q_last;
  logic                   q_nonempty;
  logic [CNT_W-1:0]       q_count;

  assign cfg_ready = 1'b1;

  rlr_front #(.FRAC_BITS(FRAC_BITS), .INDEX_WIDTH(INDEX_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_stall, .neg_lower, .upper, .neuron_index, .last_in,
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index, .cfg_data, .q_count,
    .push, .push_item, .push_idx, .push_last
  );

  rlr_queue #(.INDEX_WIDTH(INDEX_WIDTH)) u_queue (
    .clk, .rst, .push, .push_item, .push_idx, .push_last, .pop,
    .pop_item(q_item), .pop_idx(q_idx), .pop_last(q_last),
    .nonempty(q_nonempty), .count(q_count)
  );

  rlr_back #(.FRAC_BITS(FRAC_BITS), .INDEX_WIDTH(INDEX_WIDTH)) u_back (
    .clk, .rst, .q_nonempty, .q_item, .q_idx, .q_last, .pop,
    .out_valid, .out_stall, .out_neg_lower, .out_upper, .lower_slope, .upper_slope,
    .upper_offset, .has_aux, .aux_lower_slope, .index_out, .last_out
  );

endmodule

/* rtl/rlr_checker.sv */
// port checker for the relu relaxation unit and its bind
module rlr_checker import rlr_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int INDEX_WIDTH = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [31:0]            out_neg_lower,
  input logic [30:0]            out_upper,
  input logic [16:0]            lower_slope,
  input logic [16:0]            upper_slope,
  input logic [30:0]            upper_offset,
  input logic                   has_aux,
  input logic [16:0]            aux_lower_slope,
  input logic [INDEX_WIDTH-1:0] index_out
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(upper_offset) && $stable(index_out))
    else $error("stalled item changed");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("item after reset");

  a_inactive: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_upper == 31'd0 |->
      lower_slope == 17'd0 && upper_slope == 17'd0 && upper_offset == 31'd0)
    else $error("inactive neuron with nonzero bounds");

  a_aux: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_aux |-> out_upper != 31'd0 && out_neg_lower == 32'd0)
    else $error("aux slope on non crossing neuron");

  a_noaux: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_aux |-> aux_lower_slope == 17'd0)
    else $error("aux slope without has_aux");

endmodule

bind relu_linear_relaxation_top rlr_checker #(
  .FRAC_BITS(FRAC_BITS), .INDEX_WIDTH(INDEX_WIDTH)
) u_rlr_checker (.*);
